// ===== rtl/core/vgd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the voxel grid downsampler.
// Depends on nothing; the datapath, controller, top level and testbench import it.
package vgd_pkg;

    localparam int POS_W      = 32;   // Q16.16 coordinate
    localparam int CSUM_W     = 56;   // coordinate sum
    localparam int FEAT_W     = 16;   // Q8.8 feature
    localparam int FSUM_W     = 40;   // feature sum
    localparam int CNT_W      = 24;   // point and vote counts
    localparam int OUT_FEATS  = 8;    // feature slots on the ports
    localparam int CLASS_W    = 4;
    localparam int GRID_W     = 31;
    localparam int FCNT_W     = 4;
    localparam int DIV_W      = 56;   // divider dividend width
    localparam int DIVISOR_W  = 32;
    localparam int STAT_W     = 3;
    localparam int OP_W       = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 232;
    localparam int M_TDATA_W  = 256;

    localparam logic [CNT_W-1:0]  CNT_MAX    = '1;
    localparam logic [GRID_W-1:0] GRID_RESET = 31'd65536;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    localparam logic [STAT_W-1:0] ST_MERGED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_NEW     = 3'd1;
    localparam logic [STAT_W-1:0] ST_DROPPED = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMITTED = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEATURE_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LABELS_ENABLED = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              latch;       // capture the accepted item
        logic              div_start;
        logic              key_cap;     // store floor quotient as key axis, advance op
        logic              srch_clr;
        logic              key_rd;
        logic              srch_next;
        logic              open_entry;  // write a new entry at the fill point
        logic              acc_rd;
        logic              acc_wr;
        logic              drain_rd;
        logic              mean_cap;    // store truncated quotient, advance op
        logic              cls_clr;
        logic              cls_step;
        logic              drain_adv;
        logic              set_status;
        logic [STAT_W-1:0] status;
        logic              out_load;
    } vgd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic item_fetch;
        logic div_done;
        logic key_last;
        logic mean_last;
        logic srch_end;
        logic key_match;
        logic full;
        logic saturated;
        logic drain_empty;
        logic cls_last;
        logic out_free;
    } vgd_stat_t;

endpackage

// ===== rtl/core/vgd_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vgd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/core/vgd_div.sv =====
`timescale 1ns / 1ps
// Radix-2 restoring divider: signed dividend, positive divisor, quotient truncated
// toward zero, one quotient bit per cycle. Depends on nothing.
module vgd_div #(
    parameter int DW = 56,
    parameter int VW = 32
) (
    input  logic          clk,
    input  logic          rstn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient,
    output logic          rem_nz
);
    localparam int CW = $clog2(DW + 1);

    logic          run_reg, done_reg, neg_reg;
    logic [CW-1:0] cnt_reg;
    logic [VW-1:0] rem_reg, dvs_reg;
    logic [DW-1:0] quo_reg;
    logic [VW:0]   trial;
    logic          ge;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk) begin
        if (!rstn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
                rem_reg <= '0;
                dvs_reg <= divisor;
                neg_reg <= dividend[DW-1];
                quo_reg <= dividend[DW-1] ? (~dividend + 1'b1) : dividend;
            end else if (run_reg) begin
                rem_reg <= ge ? VW'(trial - {1'b0, dvs_reg}) : trial[VW-1:0];
                quo_reg <= {quo_reg[DW-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DW - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign rem_nz   = |rem_reg;
endmodule

// ===== rtl/core/vgd_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: item registers, voxel table memories, shared divider, majority scan
// and output register. Depends on vgd_pkg, vgd_ram and vgd_div.
module vgd_datapath #(
    parameter int MAX_VOXELS    = 1024,
    parameter int FEATURE_SLOTS = 8,
    parameter int LABEL_CLASSES = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  vgd_pkg::vgd_cmd_t                cmd,
    output vgd_pkg::vgd_stat_t               stat,
    input  logic [vgd_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             s_tuser,
    input  logic [vgd_pkg::GRID_W-1:0]       grid_size,
    input  logic [vgd_pkg::FCNT_W-1:0]       feature_count,
    input  logic                             labels_enabled,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [vgd_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [vgd_pkg::STAT_W-1:0]       m_tuser,
    output logic                             m_tlast
);
    import vgd_pkg::*;

    localparam int AW      = (MAX_VOXELS > 1) ? $clog2(MAX_VOXELS) : 1;
    localparam int UW      = $clog2(MAX_VOXELS + 1);
    localparam int LW      = $clog2(LABEL_CLASSES);
    localparam int KEY_W   = 3 * POS_W;
    localparam int CROW_W  = 3 * CSUM_W;
    localparam int FROW_W  = FEATURE_SLOTS * FSUM_W;
    localparam int VROW_W  = LABEL_CLASSES * CNT_W;
    localparam int NUM_OPS = 3 + FEATURE_SLOTS;

    // Item registers
    logic               cmd_reg;
    logic [POS_W-1:0]   pos_reg  [3];
    logic [FEAT_W-1:0]  feat_reg [OUT_FEATS];
    logic [CLASS_W-1:0] class_reg;

    logic [POS_W-1:0]   key_reg [3];
    logic [OP_W-1:0]    op_reg;
    logic [UW-1:0]      idx_reg, used_reg, drain_reg;
    logic [POS_W-1:0]   mean_c_reg [3];
    logic [FEAT_W-1:0]  mean_f_reg [FEATURE_SLOTS];
    logic [LW-1:0]      cls_reg, bc_reg;
    logic [CNT_W-1:0]   best_reg;
    logic [STAT_W-1:0]  st_reg;
    logic               last_reg;

    logic                 m_valid_reg, m_last_reg;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [STAT_W-1:0]    m_user_reg;

    // Memory ports
    logic [KEY_W-1:0]  key_rd;
    logic [CNT_W-1:0]  cnt_rd, cnt_wd;
    logic [CROW_W-1:0] crd, cwd;
    logic [FROW_W-1:0] frd, fwd;
    logic [VROW_W-1:0] vrd, vwd;
    logic              d_we, d_re;
    logic [AW-1:0]     d_waddr, d_raddr;

    logic [FCNT_W-1:0]    nf;
    logic                 vote_ok;
    logic [DIV_W-1:0]     dvd, div_q;
    logic [DIVISOR_W-1:0] dvs;
    logic                 div_done, div_rem_nz;
    logic [POS_W-1:0]     pos_sel;
    logic [CNT_W-1:0]     n_div, vote_sel;
    logic [GRID_W-1:0]    g_eff;

    assign nf      = (feature_count > FCNT_W'(OUT_FEATS)) ? FCNT_W'(OUT_FEATS) : feature_count;
    assign vote_ok = labels_enabled && (32'(class_reg) < 32'(LABEL_CLASSES));

    // Table memories
    assign d_we    = cmd.open_entry | cmd.acc_wr;
    assign d_waddr = cmd.open_entry ? used_reg[AW-1:0] : idx_reg[AW-1:0];
    assign d_re    = cmd.acc_rd | cmd.drain_rd;
    assign d_raddr = cmd.drain_rd ? drain_reg[AW-1:0] : idx_reg[AW-1:0];

    vgd_ram #(.WIDTH(KEY_W), .DEPTH(MAX_VOXELS)) u_key_ram (
        .clk(aclk), .we(cmd.open_entry), .waddr(used_reg[AW-1:0]),
        .wdata({key_reg[2], key_reg[1], key_reg[0]}),
        .re(cmd.key_rd), .raddr(idx_reg[AW-1:0]), .rdata(key_rd)
    );
    vgd_ram #(.WIDTH(CNT_W), .DEPTH(MAX_VOXELS)) u_cnt_ram (
        .clk(aclk), .we(d_we), .waddr(d_waddr), .wdata(cnt_wd),
        .re(d_re), .raddr(d_raddr), .rdata(cnt_rd)
    );
    vgd_ram #(.WIDTH(CROW_W), .DEPTH(MAX_VOXELS)) u_coord_ram (
        .clk(aclk), .we(d_we), .waddr(d_waddr), .wdata(cwd),
        .re(d_re), .raddr(d_raddr), .rdata(crd)
    );
    vgd_ram #(.WIDTH(FROW_W), .DEPTH(MAX_VOXELS)) u_feat_ram (
        .clk(aclk), .we(d_we), .waddr(d_waddr), .wdata(fwd),
        .re(d_re), .raddr(d_raddr), .rdata(frd)
    );
    vgd_ram #(.WIDTH(VROW_W), .DEPTH(MAX_VOXELS)) u_vote_ram (
        .clk(aclk), .we(d_we), .waddr(d_waddr), .wdata(vwd),
        .re(d_re), .raddr(d_raddr), .rdata(vrd)
    );

    // Entry update: a new entry starts from zero, a merge from the stored row.
    always_comb begin
        logic [CSUM_W-1:0] cbase;
        logic [FSUM_W-1:0] fbase;
        logic [CNT_W-1:0]  vbase;
        cnt_wd = (cmd.open_entry ? '0 : cnt_rd) + 1'b1;
        for (int a = 0; a < 3; a++) begin
            cbase = cmd.open_entry ? '0 : crd[a*CSUM_W +: CSUM_W];
            cwd[a*CSUM_W +: CSUM_W] = cbase +
                {{(CSUM_W-POS_W){pos_reg[a][POS_W-1]}}, pos_reg[a]};
        end
        for (int k = 0; k < FEATURE_SLOTS; k++) begin
            fbase = cmd.open_entry ? '0 : frd[k*FSUM_W +: FSUM_W];
            fwd[k*FSUM_W +: FSUM_W] = fbase;
            if (FCNT_W'(k) < nf) begin
                fwd[k*FSUM_W +: FSUM_W] = fbase +
                    {{(FSUM_W-FEAT_W){feat_reg[k][FEAT_W-1]}}, feat_reg[k]};
            end
        end
        for (int c = 0; c < LABEL_CLASSES; c++) begin
            vbase = cmd.open_entry ? '0 : vrd[c*CNT_W +: CNT_W];
            vwd[c*CNT_W +: CNT_W] = vbase;
            if (vote_ok && (LW'(class_reg) == LW'(c))) begin
                vwd[c*CNT_W +: CNT_W] = vbase + 1'b1;
            end
        end
    end

    // Divider operands
    assign g_eff = (grid_size == '0) ? GRID_W'(1) : grid_size;
    assign n_div = (cnt_rd == '0) ? CNT_W'(1) : cnt_rd;

    always_comb begin
        pos_sel = pos_reg[2];
        if (op_reg == OP_W'(0)) begin
            pos_sel = pos_reg[0];
        end else if (op_reg == OP_W'(1)) begin
            pos_sel = pos_reg[1];
        end
        if (cmd_reg == CMD_ADD) begin
            dvd = {{(DIV_W-POS_W){pos_sel[POS_W-1]}}, pos_sel};
            dvs = DIVISOR_W'(g_eff);
        end else begin
            dvd = '0;
            for (int a = 0; a < 3; a++) begin
                if (op_reg == OP_W'(a)) begin
                    dvd = crd[a*CSUM_W +: CSUM_W];
                end
            end
            for (int k = 0; k < FEATURE_SLOTS; k++) begin
                if (op_reg == OP_W'(k + 3)) begin
                    dvd = {{(DIV_W-FSUM_W){frd[k*FSUM_W+FSUM_W-1]}}, frd[k*FSUM_W +: FSUM_W]};
                end
            end
            dvs = DIVISOR_W'(n_div);
        end
    end

    vgd_div #(.DW(DIV_W), .VW(DIVISOR_W)) u_div (
        .clk(aclk), .rstn(aresetn), .start(cmd.div_start),
        .dividend(dvd), .divisor(dvs),
        .done(div_done), .quotient(div_q), .rem_nz(div_rem_nz)
    );

    always_comb begin
        vote_sel = '0;
        for (int c = 0; c < LABEL_CLASSES; c++) begin
            if (cls_reg == LW'(c)) begin
                vote_sel = vrd[c*CNT_W +: CNT_W];
            end
        end
    end

    // Result word
    always_comb begin
        m_data_next = '0;
        if (st_reg == ST_EMITTED) begin
            m_data_next[31:0]  = mean_c_reg[0];
            m_data_next[63:32] = mean_c_reg[1];
            m_data_next[95:64] = mean_c_reg[2];
            for (int k = 0; k < FEATURE_SLOTS; k++) begin
                if (FCNT_W'(k) < nf) begin
                    m_data_next[96 + k*FEAT_W +: FEAT_W] = mean_f_reg[k];
                end
            end
            m_data_next[227:224] = labels_enabled ? CLASS_W'(bc_reg) : '0;
            m_data_next[251:228] = cnt_rd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            drain_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.latch) begin
                cmd_reg   <= s_tuser;
                pos_reg[0] <= s_tdata[31:0];
                pos_reg[1] <= s_tdata[63:32];
                pos_reg[2] <= s_tdata[95:64];
                for (int k = 0; k < OUT_FEATS; k++) begin
                    feat_reg[k] <= s_tdata[96 + k*FEAT_W +: FEAT_W];
                end
                class_reg <= s_tdata[227:224];
                op_reg    <= '0;
                last_reg  <= 1'b0;
            end
            if (cmd.key_cap) begin
                for (int a = 0; a < 3; a++) begin
                    if (op_reg == OP_W'(a)) begin
                        key_reg[a] <= div_q[POS_W-1:0] - POS_W'(pos_sel[POS_W-1] & div_rem_nz);
                    end
                end
                op_reg <= op_reg + 1'b1;
            end
            if (cmd.mean_cap) begin
                for (int a = 0; a < 3; a++) begin
                    if (op_reg == OP_W'(a)) begin
                        mean_c_reg[a] <= div_q[POS_W-1:0];
                    end
                end
                for (int k = 0; k < FEATURE_SLOTS; k++) begin
                    if (op_reg == OP_W'(k + 3)) begin
                        mean_f_reg[k] <= div_q[FEAT_W-1:0];
                    end
                end
                op_reg <= op_reg + 1'b1;
            end
            if (cmd.srch_clr) begin
                idx_reg <= '0;
            end else if (cmd.srch_next) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.open_entry) begin
                used_reg <= used_reg + 1'b1;
            end
            if (cmd.cls_clr) begin
                cls_reg  <= '0;
                bc_reg   <= '0;
                best_reg <= '0;
            end else if (cmd.cls_step) begin
                if (vote_sel > best_reg) begin
                    best_reg <= vote_sel;
                    bc_reg   <= cls_reg;
                end
                cls_reg <= cls_reg + 1'b1;
            end
            if (cmd.drain_adv) begin
                if ((drain_reg + 1'b1) >= used_reg) begin
                    used_reg  <= '0;
                    drain_reg <= '0;
                    last_reg  <= 1'b1;
                end else begin
                    drain_reg <= drain_reg + 1'b1;
                end
            end
            if (cmd.set_status) begin
                st_reg <= cmd.status;
            end
            // Output register: hold until taken, reload in the same cycle if asked.
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= m_data_next;
                m_user_reg  <= st_reg;
                m_last_reg  <= last_reg;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    assign stat.item_fetch  = cmd_reg;
    assign stat.div_done    = div_done;
    assign stat.key_last    = op_reg == OP_W'(2);
    assign stat.mean_last   = op_reg == OP_W'(NUM_OPS - 1);
    assign stat.srch_end    = idx_reg == used_reg;
    assign stat.key_match   = key_rd == {key_reg[2], key_reg[1], key_reg[0]};
    assign stat.full        = used_reg == UW'(MAX_VOXELS);
    assign stat.saturated   = cnt_rd == CNT_MAX;
    assign stat.drain_empty = drain_reg >= used_reg;
    assign stat.cls_last    = cls_reg == LW'(LABEL_CLASSES - 1);
    assign stat.out_free    = !m_valid_reg || m_tready;
endmodule

// ===== rtl/core/vgd_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: sequences key division, table search, update and
// voxel drain. Depends on vgd_pkg.
module vgd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  vgd_pkg::vgd_stat_t stat,
    output vgd_pkg::vgd_cmd_t  cmd
);
    import vgd_pkg::*;

    typedef enum logic [3:0] {
        IDLE, K_START, K_WAIT, S_READ, S_CMP, N_OPEN, A_READ, A_WRITE,
        F_CHECK, F_START, F_WAIT, M_SCAN, F_DONE, RESP
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = K_START;
                end
            end
            K_START: begin
                // Fetch items skip the key divisions.
                if (stat.item_fetch) begin
                    state_next = F_CHECK;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = K_WAIT;
                end
            end
            K_WAIT: begin
                if (stat.div_done) begin
                    cmd.key_cap = 1'b1;
                    if (stat.key_last) begin
                        cmd.srch_clr = 1'b1;
                        state_next   = S_READ;
                    end else begin
                        state_next = K_START;
                    end
                end
            end
            S_READ: begin
                if (stat.srch_end) begin
                    state_next = N_OPEN;
                end else begin
                    cmd.key_rd = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (stat.key_match) begin
                    state_next = A_READ;
                end else begin
                    cmd.srch_next = 1'b1;
                    state_next    = S_READ;
                end
            end
            N_OPEN: begin
                cmd.set_status = 1'b1;
                if (stat.full) begin
                    cmd.status = ST_DROPPED;
                end else begin
                    cmd.status     = ST_NEW;
                    cmd.open_entry = 1'b1;
                end
                state_next = RESP;
            end
            A_READ: begin
                cmd.acc_rd = 1'b1;
                state_next = A_WRITE;
            end
            A_WRITE: begin
                cmd.acc_wr     = !stat.saturated;
                cmd.set_status = 1'b1;
                cmd.status     = ST_MERGED;
                state_next     = RESP;
            end
            F_CHECK: begin
                if (stat.drain_empty) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_EMPTY;
                    state_next     = RESP;
                end else begin
                    cmd.drain_rd = 1'b1;
                    state_next   = F_START;
                end
            end
            F_START: begin
                cmd.div_start = 1'b1;
                state_next    = F_WAIT;
            end
            F_WAIT: begin
                if (stat.div_done) begin
                    cmd.mean_cap = 1'b1;
                    if (stat.mean_last) begin
                        cmd.cls_clr = 1'b1;
                        state_next  = M_SCAN;
                    end else begin
                        state_next = F_START;
                    end
                end
            end
            M_SCAN: begin
                cmd.cls_step = 1'b1;
                if (stat.cls_last) begin
                    state_next = F_DONE;
                end
            end
            F_DONE: begin
                cmd.drain_adv  = 1'b1;
                cmd.set_status = 1'b1;
                cmd.status     = ST_EMITTED;
                state_next     = RESP;
            end
            RESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = state_reg == IDLE;
endmodule

// ===== rtl/core/voxel_grid_downsampler.sv =====
`timescale 1ns / 1ps
// Voxel grid downsampler, top level. Depends on vgd_pkg, vgd_ctrl, vgd_datapath.
// Add: three key divisions on the one shared divider, then a search that reads and
//   compares each open voxel in turn, then the update or drop and the output.
// Fetch: 3 + FEATURE_SLOTS mean divisions on the same divider plus a vote scan over
//   LABEL_CLASSES classes; an empty table reports empty. One item is in work at a time.
// Reset (aresetn low, synchronous) empties the table and restores the registers.
module voxel_grid_downsampler #(
    parameter int MAX_VOXELS    = 1024,
    parameter int FEATURE_SLOTS = 8,
    parameter int LABEL_CLASSES = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pos_x, pos_y, pos_z, feat_lo, feat_hi, class_id, zero pad
    input  logic [vgd_pkg::S_TDATA_W-1:0]    s_tdata,
    // cmd
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // mean_x, mean_y, mean_z, mean_feat_lo, mean_feat_hi, majority_class,
    // point_count, zero pad
    output logic [vgd_pkg::M_TDATA_W-1:0]    m_tdata,
    // status
    output logic [vgd_pkg::STAT_W-1:0]       m_tuser,
    output logic                             m_tlast,
    input  logic                             cfg_we,
    input  logic [vgd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vgd_pkg::GRID_W-1:0]       cfg_wdata
);
    import vgd_pkg::*;

    logic [GRID_W-1:0] grid_reg;
    logic [FCNT_W-1:0] fcnt_reg;
    logic              labels_reg;
    vgd_cmd_t          cmd;
    vgd_stat_t         stat;

    // Configuration registers; an index past the list writes nothing.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_reg   <= GRID_RESET;
            fcnt_reg   <= '0;
            labels_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_GRID_SIZE:      grid_reg   <= cfg_wdata;
                REG_FEATURE_COUNT:  fcnt_reg   <= cfg_wdata[FCNT_W-1:0];
                REG_LABELS_ENABLED: labels_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Controller: one item at a time, ready only while idle.
    vgd_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .stat(stat), .cmd(cmd)
    );

    // Datapath: table memories, divider, vote scan and output register.
    vgd_datapath #(
        .MAX_VOXELS(MAX_VOXELS), .FEATURE_SLOTS(FEATURE_SLOTS),
        .LABEL_CLASSES(LABEL_CLASSES)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .s_tdata(s_tdata), .s_tuser(s_tuser),
        .grid_size(grid_reg), .feature_count(fcnt_reg), .labels_enabled(labels_reg),
        .m_tready(m_tready), .m_tvalid(m_tvalid), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );
endmodule

// ===== tb/tb_voxel_grid_downsampler.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of voxel_grid_downsampler: directed and random point and
// fetch traffic, a built-in voxel table predictor and an in-order result check.
// Depends on vgd_pkg and the voxel_grid_downsampler RTL.
module tb_voxel_grid_downsampler;
    import vgd_pkg::*;

    localparam int NVOX     = 1024;
    localparam int NSLOT    = 8;
    localparam int NCLASS   = 16;
    localparam int WDOG_MAX = 20000;   // watchdog limit, well above a full-table search
    localparam logic [GRID_W-1:0] GRID_MAX = '1;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] px, py, pz;
        logic [63:0]        flo, fhi;
        logic [3:0]         cls;
    } point_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic signed [31:0] mx, my, mz;
        logic [63:0]        mflo, mfhi;
        logic [3:0]         maj;
        logic [23:0]        cnt;
        logic               last;
    } voxel_out_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]    m_tuser;
    logic                 m_tlast;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [GRID_W-1:0]    cfg_wdata = '0;

    voxel_grid_downsampler u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Shadow of the block's registers and voxel table.
    logic [GRID_W-1:0]  sh_grid = GRID_RESET;
    logic [FCNT_W-1:0]  sh_fcnt = '0;
    logic               sh_lab  = 1'b0;
    logic signed [31:0] tbl_key [NVOX][3];
    int unsigned        tbl_pts [NVOX];
    longint             tbl_csum[NVOX][3];
    longint             tbl_fsum[NVOX][NSLOT];
    int unsigned        tbl_vote[NVOX][NCLASS];
    int unsigned        tbl_used  = 0;
    int unsigned        tbl_drain = 0;

    point_item_t pending_items[$];
    voxel_out_t  expected_voxels[$];
    int          errors   = 0;
    bit          calm     = 1'b0;   // phases without idling on either side
    bit          busy     = 1'b0;
    int          src_gap  = 0;
    int          snk_hold = 0;
    point_item_t cur_item;

    function automatic longint floor_quot(longint x, longint g);
        longint q;
        q = x / g;
        if (x < 0 && (x % g) != 0) q = q - 1;
        return q;
    endfunction

    // Bin one point into the table and return its add status.
    function automatic logic [STAT_W-1:0] bin_point(point_item_t it);
        longint            g;
        longint            p[3];
        logic signed [31:0] k[3];
        int unsigned       e;
        int                nf;
        logic [15:0]       w;
        logic [STAT_W-1:0] st;
        g = (sh_grid == 0) ? 1 : longint'(sh_grid);
        p[0] = longint'(it.px);
        p[1] = longint'(it.py);
        p[2] = longint'(it.pz);
        for (int i = 0; i < 3; i++) k[i] = 32'(floor_quot(p[i], g));
        nf = (sh_fcnt > NSLOT) ? NSLOT : sh_fcnt;
        st = ST_MERGED;
        for (e = 0; e < tbl_used; e++)
            if (tbl_key[e][0] == k[0] && tbl_key[e][1] == k[1] && tbl_key[e][2] == k[2])
                break;
        if (e == tbl_used) begin
            if (tbl_used >= NVOX) return ST_DROPPED;
            for (int i = 0; i < 3; i++) begin
                tbl_key[e][i]  = k[i];
                tbl_csum[e][i] = 0;
            end
            for (int i = 0; i < NSLOT; i++) tbl_fsum[e][i] = 0;
            for (int i = 0; i < NCLASS; i++) tbl_vote[e][i] = 0;
            tbl_pts[e] = 0;
            tbl_used++;
            st = ST_NEW;
        end
        // a saturated voxel reports merged and keeps its sums
        if (tbl_pts[e] >= CNT_MAX) return st;
        tbl_pts[e]++;
        for (int i = 0; i < 3; i++) tbl_csum[e][i] += p[i];
        for (int i = 0; i < nf; i++) begin
            w = (i < 4) ? it.flo[16*(i%4) +: 16] : it.fhi[16*(i%4) +: 16];
            tbl_fsum[e][i] += longint'($signed(w));
        end
        if (sh_lab && it.cls < NCLASS) tbl_vote[e][it.cls]++;
        return st;
    endfunction

    // Emit the next voxel in order of opening, or report an empty table.
    function automatic voxel_out_t emit_voxel();
        voxel_out_t  r;
        int unsigned e;
        longint      n;
        int          nf;
        int unsigned best;
        logic [15:0] m;
        r = '0;
        if (tbl_drain >= tbl_used) begin
            r.status = ST_EMPTY;
            return r;
        end
        e = tbl_drain;
        n = (tbl_pts[e] == 0) ? 1 : tbl_pts[e];
        nf = (sh_fcnt > NSLOT) ? NSLOT : sh_fcnt;
        r.status = ST_EMITTED;
        r.mx = 32'(tbl_csum[e][0] / n);
        r.my = 32'(tbl_csum[e][1] / n);
        r.mz = 32'(tbl_csum[e][2] / n);
        for (int i = 0; i < nf; i++) begin
            m = 16'(tbl_fsum[e][i] / n);
            if (i < 4) r.mflo[16*i +: 16] = m;
            else       r.mfhi[16*(i-4) +: 16] = m;
        end
        if (sh_lab) begin
            best = 0;
            for (int c = 0; c < NCLASS; c++)
                if (tbl_vote[e][c] > best) begin
                    best  = tbl_vote[e][c];
                    r.maj = 4'(c);
                end
        end
        r.cnt = 24'(tbl_pts[e]);
        tbl_drain++;
        if (tbl_drain >= tbl_used) begin
            r.last    = 1'b1;
            tbl_used  = 0;
            tbl_drain = 0;
        end
        return r;
    endfunction

    function automatic voxel_out_t predict_result(point_item_t it);
        voxel_out_t r;
        if (it.cmd == CMD_FETCH) return emit_voxel();
        r = '0;
        r.status = bin_point(it);
        return r;
    endfunction

    // Driver: present pending items, with a random gap after each accepted one outside calm phases.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_voxels.push_back(predict_result(cur_item));
                busy    = 1'b0;
                src_gap = calm ? 0 : $urandom_range(0, 6);
            end
            if (!busy) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    s_tdata  <= {4'b0, cur_item.cls, cur_item.fhi, cur_item.flo,
                                 cur_item.pz, cur_item.py, cur_item.px};
                    s_tuser  <= cur_item.cmd;
                    busy     = 1'b1;
                end
            end
            s_tvalid <= busy;
        end
    end

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // Monitor: stall at random, then compare each transaction with the oldest prediction.
    always @(posedge aclk) begin
        voxel_out_t ev;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_voxels.size() == 0) begin
                    $error("result transaction with no prediction pending");
                    errors++;
                end else begin
                    ev = expected_voxels.pop_front();
                    check_field("status",         64'(ev.status),    64'(m_tuser));
                    check_field("mean_x",         64'(ev.mx[31:0]),  64'(m_tdata[31:0]));
                    check_field("mean_y",         64'(ev.my[31:0]),  64'(m_tdata[63:32]));
                    check_field("mean_z",         64'(ev.mz[31:0]),  64'(m_tdata[95:64]));
                    check_field("mean_feat_lo",   ev.mflo,           m_tdata[159:96]);
                    check_field("mean_feat_hi",   ev.mfhi,           m_tdata[223:160]);
                    check_field("majority_class", 64'(ev.maj),       64'(m_tdata[227:224]));
                    check_field("point_count",    64'(ev.cnt),       64'(m_tdata[251:228]));
                    check_field("last",           64'(ev.last),      64'(m_tlast));
                end
                snk_hold = calm ? 0 : $urandom_range(0, 6);
            end else if (snk_hold > 0) begin
                snk_hold--;
            end
            m_tready <= (snk_hold == 0);
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WDOG_MAX) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic add_point(longint x, longint y, longint z,
                             logic [63:0] flo, logic [63:0] fhi, logic [3:0] cls);
        point_item_t it;
        it.cmd = CMD_ADD;
        it.px = x; it.py = y; it.pz = z;
        it.flo = flo; it.fhi = fhi; it.cls = cls;
        pending_items.push_back(it);
    endtask

    task automatic add_noise();
        add_point($signed($urandom()), $signed($urandom()), $signed($urandom()),
                  rand64(), rand64(), $urandom_range(0, 15));
    endtask

    task automatic fetch_voxel();
        point_item_t it;
        it = '0;
        it.cmd = CMD_FETCH;
        it.flo = rand64();   // payload of a fetch is don't-care; toggle it anyway
        it.cls = $urandom_range(0, 15);
        pending_items.push_back(it);
    endtask

    // Hold until every item is accepted and every result has come back.
    task automatic wait_idle();
        while (pending_items.size() != 0 || busy || expected_voxels.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_config(logic [GRID_W-1:0] g, logic [FCNT_W-1:0] fc, logic lab);
        @(posedge aclk);
        cfg_we <= 1'b1; cfg_index <= REG_GRID_SIZE; cfg_wdata <= g;
        sh_grid = g;
        @(posedge aclk);
        cfg_index <= REG_FEATURE_COUNT; cfg_wdata <= fc;
        sh_fcnt = fc;
        @(posedge aclk);
        cfg_index <= REG_LABELS_ENABLED; cfg_wdata <= lab;
        sh_lab = lab;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        longint g, base_x, base_y, base_z, spread;
        int     n_add, rand_items;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: unit grid, feature count above the slot count, labels on.
        write_config(GRID_W'(1), 4'd15, 1'b1);
        fetch_voxel();                                     // fetch on an empty table
        add_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000, 4'd15);
        add_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF, 4'd0);
        add_point(0, 0, 0, 64'h0001_FFFF_0003_FFFD, 64'h1234_8765_0000_FFFF, 4'd5);
        add_point(0, 0, 0, 64'hFFFF_0001_FFFE_0002, 64'h0000_0001_7FFF_8000, 4'd3);
        fetch_voxel();
        // add while draining, including a merge into an already emitted voxel
        add_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, rand64(), rand64(), 4'd1);
        add_point(-1, -1, -1, rand64(), rand64(), 4'd9);
        repeat (4) fetch_voxel();
        wait_idle();

        // Zero grid acts as one; features and labels off.
        write_config('0, 4'd0, 1'b0);
        add_point(-3, 5, 7, rand64(), rand64(), 4'd2);
        add_point(-3, 5, 7, rand64(), rand64(), 4'd2);
        add_point(3, 5, 7, rand64(), rand64(), 4'd2);
        repeat (3) fetch_voxel();
        wait_idle();

        // Largest grid: only a handful of voxels span the whole range.
        write_config(GRID_MAX, 4'd8, 1'b1);
        add_point(32'sh8000_0000, -1, 0, rand64(), rand64(), 4'd7);
        add_point(-1, 0, 32'sh7FFF_FFFF, rand64(), rand64(), 4'd7);
        add_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, rand64(), rand64(), 4'd4);
        add_point(32'sh7FFF_FFFE, 32'sh7FFF_FFFE, 32'sh7FFF_FFFE, rand64(), rand64(), 4'd7);
        repeat (4) fetch_voxel();
        wait_idle();

        // Fill the table, then drop a new voxel and merge into an open one.
        write_config(GRID_W'(1), 4'd3, 1'b1);
        for (int i = 0; i < NVOX; i++) add_point(i, -i, i, rand64(), rand64(), i % 16);
        add_point(NVOX, 0, 0, rand64(), rand64(), 4'd1);
        add_point(5, -5, 5, rand64(), rand64(), 4'd1);
        for (int i = 0; i <= NVOX; i++) fetch_voxel();
        wait_idle();

        // Random phases: clustered batches followed by a full drain.
        rand_items = 0;
        while (rand_items < 1200) begin
            case ($urandom_range(0, 4))
                0: write_config(GRID_W'($urandom_range(1, 8)), $urandom_range(0, 15),
                                $urandom_range(0, 1));
                1: write_config(GRID_RESET, $urandom_range(0, 15), $urandom_range(0, 1));
                2: write_config(GRID_W'($urandom()), $urandom_range(0, 15),
                                $urandom_range(0, 1));
                3: write_config(GRID_MAX, $urandom_range(0, 15), $urandom_range(0, 1));
                default: write_config('0, $urandom_range(0, 15), $urandom_range(0, 1));
            endcase
            calm = ($urandom_range(0, 3) == 0);
            g = (sh_grid == 0) ? 1 : longint'(sh_grid);
            spread = (3 * g > 64'sd1073741824) ? 64'sd1073741824 : 3 * g;
            for (int b = 0; b < 3; b++) begin
                n_add  = $urandom_range(4, 20);
                base_x = longint'($urandom_range(0, 32'h7FFF_FFFF)) - 64'sd1073741824;
                base_y = longint'($urandom_range(0, 32'h7FFF_FFFF)) - 64'sd1073741824;
                base_z = longint'($urandom_range(0, 32'h7FFF_FFFF)) - 64'sd1073741824;
                if (base_x > 64'sd1073741823) base_x = base_x - 64'sd1073741824;
                if (base_y > 64'sd1073741823) base_y = base_y - 64'sd1073741824;
                if (base_z > 64'sd1073741823) base_z = base_z - 64'sd1073741824;
                for (int k = 0; k < n_add; k++) begin
                    if ($urandom_range(0, 7) == 0) add_noise();
                    else add_point(base_x + $urandom_range(0, spread),
                                   base_y + $urandom_range(0, spread),
                                   base_z + $urandom_range(0, spread),
                                   rand64(), rand64(), $urandom_range(0, 3));
                    if ($urandom_range(0, 9) == 0) fetch_voxel();
                end
                for (int k = 0; k <= n_add; k++) fetch_voxel();
                rand_items += 2 * n_add + 1;
            end
            wait_idle();
        end

        calm = 1'b0;
        wait_idle();
        repeat (800) @(posedge aclk);
        if (errors == 0 && expected_voxels.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
